// File: sv/rsld_pkg.sv
// Shared types, constants and elaboration-time functions for the ring sensor line direction block.
// No dependencies; the other files that use it refer to it by scoped names.
package rsld_pkg;

  localparam int INPUT_BITS = 16;
  localparam int SUM_W = 20;
  localparam int CW = 33;
  localparam int SCALE_SHIFT = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int ATAN_ENTRIES = 24;
  localparam int DIR_W = 10;

  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;
  localparam logic [31:0] ROUND_UP = 32'hFFFF_FFFF;
  localparam longint ONE_Q14 = 16384;
  localparam longint DIAG_Q14 = 11585;
  localparam longint CORDIC_GAIN_INV = 652032874;
  localparam logic [DIR_W-1:0] DEGREES_PER_TURN = 10'd360;
  localparam logic signed [DIR_W-1:0] DIR_NONE = -10'sd1;
  localparam logic signed [DIR_W-1:0] DIR_ZERO = 10'sd0;

  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  typedef struct packed {
    logic any;
    logic zero;
    logic [1:0] quad;
    logic signed [SUM_W-1:0] x;
    logic signed [SUM_W-1:0] y;
  } entry_t;

  function automatic longint to_q14(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r < 0) r = 0;
    if (r > ONE_Q14) r = ONE_Q14;
    return r;
  endfunction

  function automatic logic [31:0] rotate_small(logic [31:0] a, int iters);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint c;
    longint s;
    x = CORDIC_GAIN_INV;
    y = 0;
    z = longint'({32'b0, a});
    for (int i = 0; i < iters && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z > 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'({32'b0, ATAN_TURNS[i]});
      end else if (z < 0) begin
        x = x + dx;
        y = y - dy;
        z = z + longint'({32'b0, ATAN_TURNS[i]});
      end
    end
    c = to_q14(x);
    s = to_q14(y);
    return {c[15:0], s[15:0]};
  endfunction

  function automatic logic [31:0] unit_vec(logic [31:0] ang, int iters);
    logic [1:0] q;
    logic [31:0] r;
    logic [31:0] cs;
    longint c;
    longint s;
    longint vx;
    longint vy;
    q = ang[31:30];
    r = {2'b00, ang[29:0]};
    if (r == 32'd0) begin
      c = ONE_Q14;
      s = 0;
    end else if (r == EIGHTH_TURN) begin
      c = DIAG_Q14;
      s = DIAG_Q14;
    end else if (r < EIGHTH_TURN) begin
      cs = rotate_small(r, iters);
      c = longint'({48'b0, cs[31:16]});
      s = longint'({48'b0, cs[15:0]});
    end else begin
      cs = rotate_small(QUARTER_TURN - r, iters);
      s = longint'({48'b0, cs[31:16]});
      c = longint'({48'b0, cs[15:0]});
    end
    case (q)
      2'd0: begin vx = c; vy = s; end
      2'd1: begin vx = -s; vy = c; end
      2'd2: begin vx = -c; vy = -s; end
      default: begin vx = s; vy = -c; end
    endcase
    return {vx[15:0], vy[15:0]};
  endfunction

endpackage

// File: sv/rsld_front.sv
// Front end: accepts hit masks, sums sensor unit vectors in a registered tree and classifies.
// Depends on rsld_pkg for the unit vector function and the queue entry type.
module rsld_front #(
  parameter int NUM_SENSORS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [rsld_pkg::INPUT_BITS-1:0] sensor_hits,
  input  logic q_full,
  output logic q_push,
  output rsld_pkg::entry_t q_entry
);

  localparam int NE = (NUM_SENSORS < rsld_pkg::INPUT_BITS) ? NUM_SENSORS : rsld_pkg::INPUT_BITS;
  localparam int NG = (NE + 3) / 4;
  localparam int SW = rsld_pkg::SUM_W;

  logic signed [SW-1:0] vec_x [NE];
  logic signed [SW-1:0] vec_y [NE];

  for (genvar k = 0; k < NE; k++) begin : g_vec
    localparam logic [31:0] ANG = 32'((64'(k) << 32) / NUM_SENSORS);
    localparam logic [31:0] VEC = rsld_pkg::unit_vec(ANG, CORDIC_ITERATIONS);
    assign vec_x[k] = SW'(signed'(VEC[31:16]));
    assign vec_y[k] = SW'(signed'(VEC[15:0]));
  end

  logic front_en;
  logic f1v, f2v, f3v, f4v;
  logic [NE-1:0] f1_hits;
  logic signed [SW-1:0] gsum_x [NG];
  logic signed [SW-1:0] gsum_y [NG];
  logic signed [SW-1:0] f2_x [NG];
  logic signed [SW-1:0] f2_y [NG];
  logic f2_any;
  logic signed [SW-1:0] tot_x, tot_y;
  logic signed [SW-1:0] f3_x, f3_y;
  logic f3_any;
  rsld_pkg::entry_t f4_entry, cls;

  assign front_en = !f4v || !q_full;
  assign in_ready = front_en;
  assign q_push = f4v && !q_full;
  assign q_entry = f4_entry;

  for (genvar g = 0; g < NG; g++) begin : g_grp
    always_comb begin
      gsum_x[g] = '0;
      gsum_y[g] = '0;
      for (int j = 0; j < 4; j++) begin
        if (g * 4 + j < NE) begin
          if (f1_hits[g * 4 + j]) begin
            gsum_x[g] = gsum_x[g] + vec_x[g * 4 + j];
            gsum_y[g] = gsum_y[g] + vec_y[g * 4 + j];
          end
        end
      end
    end
  end

  always_comb begin
    tot_x = '0;
    tot_y = '0;
    for (int g = 0; g < NG; g++) begin
      tot_x = tot_x + f2_x[g];
      tot_y = tot_y + f2_y[g];
    end
  end

  // Turn a nonzero sum by whole quarter turns into x > 0, y >= 0.
  always_comb begin
    cls.any = f3_any;
    cls.zero = (f3_x == '0) && (f3_y == '0);
    if (f3_x > 0 && f3_y >= 0) begin
      cls.quad = 2'd0;
      cls.x = f3_x;
      cls.y = f3_y;
    end else if (f3_x <= 0 && f3_y > 0) begin
      cls.quad = 2'd1;
      cls.x = f3_y;
      cls.y = -f3_x;
    end else if (f3_x < 0 && f3_y <= 0) begin
      cls.quad = 2'd2;
      cls.x = -f3_x;
      cls.y = -f3_y;
    end else begin
      cls.quad = 2'd3;
      cls.x = -f3_y;
      cls.y = f3_x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1v <= 1'b0;
      f2v <= 1'b0;
      f3v <= 1'b0;
      f4v <= 1'b0;
    end else if (front_en) begin
      f1v <= in_valid;
      f2v <= f1v;
      f3v <= f2v;
      f4v <= f3v;
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      f1_hits <= sensor_hits[NE-1:0];
      f2_x <= gsum_x;
      f2_y <= gsum_y;
      f2_any <= |f1_hits;
      f3_x <= tot_x;
      f3_y <= tot_y;
      f3_any <= f2_any;
      f4_entry <= cls;
    end
  end

endmodule

// File: sv/rsld_queue.sv
// Short FIFO between the front end and the CORDIC back end.
// Depends on rsld_pkg for the entry type and the queue depth.
module rsld_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rsld_pkg::entry_t wr_entry,
  output logic full,
  input  logic pop,
  output rsld_pkg::entry_t rd_entry,
  output logic empty
);

  localparam int DEPTH = rsld_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);

  rsld_pkg::entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CNTW-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  // The read register holds the transaction popped last and serves as the back end's load stage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_entry;
    end
    if (do_pop) begin
      rd_entry <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) count <= count + CNTW'(1);
      else if (do_pop && !do_push) count <= count - CNTW'(1);
    end
  end

endmodule

// File: sv/rsld_back.sv
// Back end: pipelined CORDIC vectoring, one iteration per stage, then degree conversion.
// Depends on rsld_pkg for the arctangent table, widths and direction codes.
module rsld_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic q_empty,
  output logic q_pop,
  input  rsld_pkg::entry_t q_entry,
  output logic out_valid,
  input  logic out_ready,
  output logic line_found,
  output logic signed [rsld_pkg::DIR_W-1:0] direction_deg
);

  localparam int N = CORDIC_ITERATIONS;
  localparam int CW = rsld_pkg::CW;
  localparam int DW = rsld_pkg::DIR_W;

  logic back_en;
  logic vld [N+1];
  logic st_any [N+1];
  logic st_zero [N+1];
  logic signed [CW-1:0] st_x [N+1];
  logic signed [CW-1:0] st_y [N+1];
  logic [31:0] st_z [N+1];
  logic [41:0] up_full;
  logic [DW-1:0] up;
  logic signed [DW-1:0] dir_next;

  assign back_en = !out_valid || out_ready;
  assign q_pop = back_en && !q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (back_en) begin
      vld[0] <= !q_empty;
    end
  end

  // The queue's read register is the load stage; it only changes on a pop.
  assign st_any[0] = q_entry.any;
  assign st_zero[0] = q_entry.zero;
  assign st_x[0] = CW'(q_entry.x) <<< rsld_pkg::SCALE_SHIFT;
  assign st_y[0] = CW'(q_entry.y) <<< rsld_pkg::SCALE_SHIFT;
  assign st_z[0] = {q_entry.quad, 30'b0};

  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = st_y[i] >>> i;
    assign dy = st_x[i] >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (back_en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (back_en) begin
        st_any[i+1] <= st_any[i];
        st_zero[i+1] <= st_zero[i];
        if (st_y[i] > 0) begin
          st_x[i+1] <= st_x[i] + dx;
          st_y[i+1] <= st_y[i] - dy;
          st_z[i+1] <= st_z[i] + rsld_pkg::ATAN_TURNS[i];
        end else if (st_y[i] < 0) begin
          st_x[i+1] <= st_x[i] - dx;
          st_y[i+1] <= st_y[i] + dy;
          st_z[i+1] <= st_z[i] - rsld_pkg::ATAN_TURNS[i];
        end else begin
          st_x[i+1] <= st_x[i];
          st_y[i+1] <= st_y[i];
          st_z[i+1] <= st_z[i];
        end
      end
    end
  end

  // Binary angle to degrees, rounded up; a full turn wraps to zero, a zero sum to 0, no hit to -1.
  always_comb begin
    up_full = 42'(st_z[N]) * 42'(rsld_pkg::DEGREES_PER_TURN) + 42'(rsld_pkg::ROUND_UP);
    up = up_full[41:32];
    if (!st_any[N]) begin
      dir_next = rsld_pkg::DIR_NONE;
    end else if (st_zero[N] || up >= rsld_pkg::DEGREES_PER_TURN) begin
      dir_next = rsld_pkg::DIR_ZERO;
    end else begin
      dir_next = signed'(up);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (back_en) begin
      out_valid <= vld[N];
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      line_found <= st_any[N];
      direction_deg <= dir_next;
    end
  end

endmodule

// File: sv/ring_sensor_line_direction.sv
// Top level of the ring sensor line direction block.
// Depends on rsld_pkg, rsld_front, rsld_queue and rsld_back.
//
// The block takes one sensor hit mask per cycle while in_ready is high and returns one
// transaction per mask with the line-found flag and the direction in whole degrees, or -1
// when no sensor is hit. Throughput is one transaction per clock while the output does
// not stall; it is set by the fully pipelined vector sum and CORDIC, with one CORDIC
// iteration per stage. An input passes through four front-end stages, one queue slot,
// one CORDIC load stage, the iteration stages and the output register. A four-entry
// queue lets the front end keep accepting while the output stalls, until it fills.
module ring_sensor_line_direction #(
  parameter int NUM_SENSORS = 16,
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [15:0] sensor_hits,
  output logic out_valid,
  input  logic out_ready,
  output logic line_found,
  output logic signed [9:0] direction_deg
);

  rsld_pkg::entry_t wr_entry, rd_entry;
  logic q_push, q_pop, q_full, q_empty;

  rsld_front #(
    .NUM_SENSORS(NUM_SENSORS),
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sensor_hits(sensor_hits),
    .q_full(q_full),
    .q_push(q_push),
    .q_entry(wr_entry)
  );

  rsld_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .wr_entry(wr_entry),
    .full(q_full),
    .pop(q_pop),
    .rd_entry(rd_entry),
    .empty(q_empty)
  );

  rsld_back #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_empty(q_empty),
    .q_pop(q_pop),
    .q_entry(rd_entry),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_found(line_found),
    .direction_deg(direction_deg)
  );

endmodule

// File: sv/rsld_checker.sv
// Port-level assertions for the ring sensor line direction block, bound to the top level.
// Depends only on the ports of ring_sensor_line_direction.
module rsld_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic [15:0] sensor_hits,
  input logic out_valid,
  input logic out_ready,
  input logic line_found,
  input logic signed [9:0] direction_deg
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_none_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !line_found) |-> (direction_deg == -10'sd1))
    else $error("no line but direction is not -1");

  a_found_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_found) |-> (!direction_deg[9] && (direction_deg < 10'sd360)))
    else $error("direction out of range");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output transaction dropped");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> ($stable(line_found) && $stable(direction_deg)))
    else $error("stalled output changed");

endmodule

bind ring_sensor_line_direction rsld_checker u_chk (.*);

// File: verif/tb_ring_sensor_line_direction.sv
// Self-checking testbench for ring_sensor_line_direction: directed and random hit masks
// under several idle and stall patterns, each result checked against a local predictor.
// Depends on rsld_pkg and the ring_sensor_line_direction RTL.
module tb_ring_sensor_line_direction;

  localparam int N_SENSORS = 16;
  localparam int CORDIC_ITERS = 16;
  localparam int LATENCY = CORDIC_ITERS + 6;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic found;
    logic signed [9:0] dir;
  } heading_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [15:0] sensor_hits;
  logic out_valid;
  logic out_ready;
  logic line_found;
  logic signed [9:0] direction_deg;

  heading_t expected_headings[$];
  heading_t want_hd;
  longint ring_x[16];
  longint ring_y[16];
  int mismatches = 0;
  int cycles = 0;
  int in_gap_pct = 0;
  int out_stall_pct = 0;

  ring_sensor_line_direction #(
    .NUM_SENSORS(N_SENSORS),
    .CORDIC_ITERATIONS(CORDIC_ITERS)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sensor_hits(sensor_hits),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_found(line_found),
    .direction_deg(direction_deg)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint q14_clip(longint v);
    longint r;
    r = (v + 64'sd32768) >>> 16;
    if (r < 0) r = 0;
    if (r > 16384) r = 16384;
    return r;
  endfunction

  function automatic void cordic_rotate(input logic [31:0] a, output longint c,
                                        output longint s);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint step;
    int i;
    x = rsld_pkg::CORDIC_GAIN_INV;
    y = 0;
    z = longint'({32'b0, a});
    for (i = 0; i < CORDIC_ITERS && i < rsld_pkg::ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = longint'({32'b0, rsld_pkg::ATAN_TURNS[i]});
      if (z > 0) begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end else if (z < 0) begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end
    end
    c = q14_clip(x);
    s = q14_clip(y);
  endfunction

  function automatic void ring_unit(input int k, output longint vx, output longint vy);
    logic [63:0] wide;
    logic [31:0] ang;
    logic [31:0] rem;
    logic [1:0] quad;
    longint c;
    longint s;
    wide = (64'(k) << 32) / 64'(N_SENSORS);
    ang = wide[31:0];
    quad = ang[31:30];
    rem = {2'b00, ang[29:0]};
    if (rem == 32'd0) begin
      c = 16384;
      s = 0;
    end else if (rem == rsld_pkg::EIGHTH_TURN) begin
      c = 11585;
      s = 11585;
    end else if (rem < rsld_pkg::EIGHTH_TURN) begin
      cordic_rotate(rem, c, s);
    end else begin
      cordic_rotate(rsld_pkg::QUARTER_TURN - rem, s, c);
    end
    case (quad)
      2'd0: begin vx = c; vy = s; end
      2'd1: begin vx = -s; vy = c; end
      2'd2: begin vx = -c; vy = -s; end
      default: begin vx = s; vy = -c; end
    endcase
  endfunction

  function automatic logic [31:0] sum_angle(longint x_in, longint y_in);
    longint x;
    longint y;
    longint t;
    longint dx;
    longint dy;
    logic [31:0] z;
    int i;
    x = x_in;
    y = y_in;
    z = 32'd0;
    for (i = 0; i < 4; i++) begin
      if (x > 0 && y >= 0) break;
      t = x;
      x = y;
      y = -t;
      z = z + rsld_pkg::QUARTER_TURN;
    end
    x = x * 2048;
    y = y * 2048;
    for (i = 0; i < CORDIC_ITERS && i < rsld_pkg::ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + rsld_pkg::ATAN_TURNS[i];
      end else if (y < 0) begin
        x = x - dx;
        y = y + dy;
        z = z - rsld_pkg::ATAN_TURNS[i];
      end
    end
    return z;
  endfunction

  function automatic heading_t predict_heading(logic [15:0] hits);
    heading_t hd;
    longint sx;
    longint sy;
    logic [31:0] z;
    logic [63:0] up;
    int k;
    sx = 0;
    sy = 0;
    hd.found = 1'b0;
    for (k = 0; k < N_SENSORS && k < 16; k++) begin
      if (hits[k]) begin
        sx = sx + ring_x[k];
        sy = sy + ring_y[k];
        hd.found = 1'b1;
      end
    end
    if (!hd.found) begin
      hd.dir = rsld_pkg::DIR_NONE;
    end else if (sx == 0 && sy == 0) begin
      hd.dir = rsld_pkg::DIR_ZERO;
    end else begin
      z = sum_angle(sx, sy);
      up = ({32'b0, z} * 64'd360 + 64'hFFFF_FFFF) >> 32;
      if (up >= 64'd360) up = 64'd0;
      hd.dir = up[9:0];
    end
    return hd;
  endfunction

  function automatic logic [15:0] random_mask();
    logic [15:0] m;
    int kind;
    int k;
    int j;
    int len;
    m = 16'h0000;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: m = 16'($urandom());
      4, 5: begin
        len = $urandom_range(1, 3);
        for (j = 0; j < len; j++) m[$urandom_range(0, 15)] = 1'b1;
      end
      6: begin
        k = $urandom_range(0, 7);
        m[k] = 1'b1;
        m[k + 8] = 1'b1;
        if ($urandom_range(0, 1) == 1) m[$urandom_range(0, 15)] = 1'b1;
      end
      7: begin
        k = $urandom_range(0, 15);
        j = $urandom_range(1, 7);
        m[(k + j) % 16] = 1'b1;
        m[(k + 16 - j) % 16] = 1'b1;
        if ($urandom_range(0, 1) == 1) m[k] = 1'b1;
      end
      8: begin
        k = $urandom_range(0, 15);
        len = $urandom_range(1, 8);
        for (j = 0; j < len; j++) m[(k + j) % 16] = 1'b1;
      end
      default: begin
        case ($urandom_range(0, 2))
          0: m = 16'h0000;
          1: m = 16'hFFFF;
          default: begin
            m = 16'hFFFF;
            m[$urandom_range(0, 15)] = 1'b0;
            m[$urandom_range(0, 15)] = 1'b0;
          end
        endcase
      end
    endcase
    return m;
  endfunction

  task automatic send_mask(input logic [15:0] m);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_gap_pct);
    end
    in_valid <= 1'b1;
    sensor_hits <= m;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_headings.push_back(predict_heading(m));
  endtask

  task automatic wait_drained();
    while (expected_headings.size() != 0) @(posedge clk);
  endtask

  task automatic note_mismatch(input heading_t want, input bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected)
        $display("unexpected transaction: found=%0b dir=%0d", line_found, direction_deg);
      else
        $display("mismatch: expected found=%0b dir=%0d, got found=%0b dir=%0d",
                 want.found, want.dir, line_found, direction_deg);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_headings.size() == 0) begin
        note_mismatch(want_hd, 1'b1);
      end else begin
        want_hd = expected_headings.pop_front();
        if (line_found !== want_hd.found || direction_deg !== want_hd.dir)
          note_mismatch(want_hd, 1'b0);
      end
    end
  end

  always @(posedge clk) begin
    if (out_stall_pct == 0) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ring_sensor_line_direction failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [15:0] masks[$];
    masks = '{16'h0000, 16'hFFFF, 16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h0010,
              16'h0100, 16'h1000, 16'h8000, 16'h0101, 16'h5555, 16'hAAAA, 16'h000A,
              16'h0011, 16'h0111, 16'h7FFF, 16'hFFFE, 16'h8001, 16'hC003, 16'h00FF,
              16'h0F0F, 16'hE001};
    in_gap_pct = 0;
    out_stall_pct = 0;
    foreach (masks[i]) send_mask(masks[i]);
  endtask

  task automatic test_random(input int count, input int gap_pct, input int stall_pct);
    in_gap_pct = gap_pct;
    out_stall_pct = stall_pct;
    repeat (count) send_mask(random_mask());
  endtask

  task automatic test_sender_pause();
    in_gap_pct = 0;
    out_stall_pct = 30;
    repeat (5) begin
      repeat (6) send_mask(random_mask());
      in_valid <= 1'b0;
      wait_drained();
    end
  endtask

  initial begin
    int k;
    rst <= 1'b1;
    in_valid <= 1'b0;
    sensor_hits <= 16'h0000;
    out_ready <= 1'b0;
    for (k = 0; k < 16; k++) begin
      ring_x[k] = 0;
      ring_y[k] = 0;
      if (k < N_SENSORS) ring_unit(k, ring_x[k], ring_y[k]);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 50, 0);
    test_sender_pause();
    test_random(400, 0, 50);
    test_random(400, 10, 10);
    in_valid <= 1'b0;
    out_stall_pct = 0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && expected_headings.size() == 0)
      $display("tb_ring_sensor_line_direction passed");
    else
      $display("tb_ring_sensor_line_direction failed");
    $finish;
  end

endmodule
